### rtl/core/nlsu_pkg.sv
package nlsu_pkg;

  // internal fixed point is signed Q.30
  localparam int IBITS = 30;
  localparam int MW    = IBITS + 1;
  localparam int PW    = 4;

  localparam logic [MW-1:0] ARG_04 = 31'd429496730;
  localparam logic [2:0]    PREC_RESET = 3'd6;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_UNSUP  = 2'd1;
  localparam logic [1:0] STATUS_DOMAIN = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLASS,
    S_RTEST,
    S_RDIV,
    S_SETUP,
    S_TGO,
    S_TDIV,
    S_T04GO,
    S_T04,
    S_MUL,
    S_MULW,
    S_MUL04,
    S_MUL04W,
    S_NEXT,
    S_KMUL,
    S_SUM,
    S_CONV,
    S_SAT,
    S_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLASSIFY,
    OP_RDIV_GO,
    OP_RDIV_END,
    OP_RFIN,
    OP_SETUP,
    OP_TDIV_GO,
    OP_TACC,
    OP_T04_GO,
    OP_T04ACC,
    OP_MUL,
    OP_MULW,
    OP_MUL04,
    OP_MUL04W,
    OP_NEXT,
    OP_KMUL,
    OP_SUM,
    OP_CONV,
    OP_SAT
  } dp_op_t;

  typedef struct packed {
    logic cls_red;
    logic cls_dir;
    logic red_more;
    logic div_done;
    logic last;
    logic dual;
  } dp_status_t;

  // least n with 10^p < 2^n * (n+1)
  function automatic logic [5:0] term_lut(input logic [PW-1:0] p);
    logic [5:0] n;
    case (p)
      4'd0:    n = 6'd1;
      4'd1:    n = 6'd2;
      4'd2:    n = 6'd5;
      4'd3:    n = 6'd7;
      4'd4:    n = 6'd10;
      4'd5:    n = 6'd13;
      4'd6:    n = 6'd16;
      4'd7:    n = 6'd19;
      4'd8:    n = 6'd23;
      4'd9:    n = 6'd26;
      4'd10:   n = 6'd29;
      4'd11:   n = 6'd32;
      4'd12:   n = 6'd35;
      4'd13:   n = 6'd38;
      4'd14:   n = 6'd42;
      default: n = 6'd45;
    endcase
    return n;
  endfunction

  // floor(k/5) + 1 for small k
  function automatic logic [PW-1:0] red_extra(input logic [5:0] k);
    logic [PW-1:0] c;
    c = PW'(1);
    for (int j = 1; j <= 6; j++) begin
      if (k >= 6'(5 * j)) c = c + PW'(1);
    end
    return c;
  endfunction

endpackage

### rtl/core/nlsu_div.sv
module nlsu_div #(
  parameter int NW = 44,
  parameter int DW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);

  // four quotient bits per cycle
  localparam int NSTEP = NW / 4;
  localparam int CW    = $clog2(NSTEP + 1);

  logic [CW-1:0] cnt;
  logic [NW-1:0] num_sh;
  logic [DW-1:0] den_r;
  logic [DW-1:0] rem;
  logic [DW-1:0] rem_next;
  logic [NW-1:0] q_next;

  always_comb begin
    logic [DW:0] t;
    logic [DW-1:0] r;
    logic [NW-1:0] qq;
    r  = rem;
    qq = quot;
    for (int j = 0; j < 4; j++) begin
      t = {r, num_sh[NW-1-j]};
      if (t >= {1'b0, den_r}) begin
        r  = DW'(t - {1'b0, den_r});
        qq = {qq[NW-2:0], 1'b1};
      end else begin
        r  = DW'(t);
        qq = {qq[NW-2:0], 1'b0};
      end
    end
    rem_next = r;
    q_next   = qq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        cnt    <= CW'(NSTEP);
        num_sh <= num;
        den_r  <= den;
        rem    <= '0;
        quot   <= '0;
      end else if (cnt != '0) begin
        cnt    <= cnt - CW'(1);
        num_sh <= num_sh << 4;
        rem    <= rem_next;
        quot   <= q_next;
        done   <= (cnt == CW'(1));
      end
    end
  end

endmodule

### rtl/core/nlsu_dp.sv
module nlsu_dp #(
  parameter int MAX_TERMS      = 32,
  parameter int MAX_REDUCTIONS = 16,
  parameter int FRAC_BITS      = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  nlsu_pkg::dp_op_t    op,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_data,
  input  logic signed [31:0]  x_value,
  output nlsu_pkg::dp_status_t st,
  output logic signed [31:0]  log_value,
  output logic [1:0]          status
);

  localparam int IBITS = nlsu_pkg::IBITS;
  localparam int MW    = nlsu_pkg::MW;
  localparam int PW    = nlsu_pkg::PW;
  localparam int SH    = IBITS - FRAC_BITS;
  localparam int XQW   = 32 + SH;
  localparam int YW    = XQW;
  localparam int NW    = ((YW + 6) / 4) * 4;
  localparam int EW    = XQW + 4;
  localparam int AW    = IBITS + 6;
  localparam int IW    = $clog2(MAX_TERMS + 1);
  localparam int KW    = $clog2(MAX_REDUCTIONS + 1);
  localparam int RW    = AW + KW + 1;

  localparam logic signed [EW-1:0]  ONE_E     = EW'(1) <<< IBITS;
  localparam logic signed [EW-1:0]  TWO_ONE   = ONE_E <<< 1;
  localparam logic signed [EW-1:0]  THREE_ONE = ONE_E * 3;
  localparam logic signed [XQW-1:0] ONE_X     = XQW'(1) <<< IBITS;
  localparam logic [YW-1:0]         ONE_Y     = YW'(1) << IBITS;
  localparam logic [NW-1:0]         SEVEN_ONE = NW'(7) << IBITS;
  localparam logic [RW-1:0]         RND       = RW'((64'(1) << SH) >> 1);
  localparam logic [RW-1:0]         POS_LIM   = RW'(32'h7fffffff);
  localparam logic [RW-1:0]         NEG_LIM   = RW'(33'h080000000);

  logic [2:0]            prec;
  logic signed [31:0]    x_reg;
  logic signed [XQW-1:0] xq;
  logic signed [EW-1:0]  xe;
  logic signed [EW-1:0]  five_x;
  logic                  out_dom;
  logic [YW-1:0]         y;
  logic [KW-1:0]         k;
  logic [NW-1:0]         five_y;
  logic                  ge7;
  logic                  u_neg;
  logic [MW-1:0]         u_mag;
  logic                  pw_neg;
  logic [MW-1:0]         pw_mag;
  logic [MW-1:0]         pw04_mag;
  logic [IW-1:0]         i;
  logic [IW-1:0]         n;
  logic                  dual;
  logic [PW-1:0]         p;
  logic [5:0]            lut_n;
  logic signed [AW-1:0]  acc;
  logic signed [AW-1:0]  acc04;
  logic signed [AW-1:0]  term_e;
  logic [2*MW-1:0]       prod;
  logic [MW-1:0]         mul_a;
  logic [MW-1:0]         mul_b;
  logic [MW-1:0]         rounded;
  logic signed [RW-1:0]  kprod;
  logic signed [RW-1:0]  res;
  logic [RW-1:0]         res_abs;
  logic                  rneg;
  logic [RW-1:0]         rmag;
  logic [RW-1:0]         sat_m;
  logic                  div_go;
  logic [NW-1:0]         div_num;
  logic [IW-1:0]         div_den;
  logic                  div_done;
  logic [NW-1:0]         quot;

  assign xq      = $signed(XQW'(x_reg)) <<< SH;
  assign xe      = EW'(xq);
  assign five_x  = (xe <<< 2) + xe;
  assign out_dom = xe <= -ONE_E;
  assign five_y  = (NW'(y) << 2) + NW'(y);
  assign ge7     = five_y >= SEVEN_ONE;
  assign lut_n   = nlsu_pkg::term_lut(p);
  assign term_e  = $signed(AW'(quot[MW-1:0]));

  assign st.cls_red  = five_x >= TWO_ONE;
  assign st.cls_dir  = five_x >= -THREE_ONE;
  assign st.red_more = ge7 && (k < KW'(MAX_REDUCTIONS));
  assign st.div_done = div_done;
  assign st.last     = (i == n);
  assign st.dual     = dual;

  assign div_go  = (op == nlsu_pkg::OP_RDIV_GO) || (op == nlsu_pkg::OP_TDIV_GO) ||
                   (op == nlsu_pkg::OP_T04_GO);
  assign div_num = (op == nlsu_pkg::OP_RDIV_GO) ? five_y :
                   (op == nlsu_pkg::OP_T04_GO)  ? NW'(pw04_mag) : NW'(pw_mag);
  assign div_den = (op == nlsu_pkg::OP_RDIV_GO) ? IW'(7) : i;

  nlsu_div #(.NW(NW), .DW(IW)) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (quot)
  );

  // one multiplier shared by both power chains
  assign mul_a   = (op == nlsu_pkg::OP_MUL04) ? pw04_mag : pw_mag;
  assign mul_b   = (op == nlsu_pkg::OP_MUL04) ? nlsu_pkg::ARG_04 : u_mag;
  assign rounded = MW'((prod + ((2*MW)'(1) << (IBITS - 1))) >> IBITS);

  assign res_abs = res[RW-1] ? RW'(-res) : RW'(res);
  assign sat_m   = rneg ? ((rmag > NEG_LIM) ? NEG_LIM : rmag)
                        : ((rmag > POS_LIM) ? POS_LIM : rmag);

  always_ff @(posedge clk) begin
    if (rst) prec <= nlsu_pkg::PREC_RESET;
    else if (cfg_we) prec <= cfg_data;
  end

  always_ff @(posedge clk) begin
    case (op)
      nlsu_pkg::OP_LOAD: x_reg <= x_value;
      nlsu_pkg::OP_CLASSIFY: begin
        if (st.cls_red) begin
          y    <= YW'(xq + ONE_X);
          k    <= '0;
          dual <= 1'b1;
        end else if (st.cls_dir) begin
          u_neg <= xq[XQW-1];
          u_mag <= xq[XQW-1] ? MW'(-xq) : MW'(xq);
          p     <= PW'(prec);
          k     <= '0;
          dual  <= 1'b0;
        end else begin
          log_value <= '0;
          status    <= out_dom ? nlsu_pkg::STATUS_DOMAIN : nlsu_pkg::STATUS_UNSUP;
        end
      end
      nlsu_pkg::OP_RDIV_END: begin
        y <= YW'(quot);
        k <= k + KW'(1);
      end
      nlsu_pkg::OP_RFIN: begin
        // reduction cap hit with y still large: fall back to 0.4
        u_neg <= 1'b0;
        u_mag <= ge7 ? nlsu_pkg::ARG_04 : MW'(y - ONE_Y);
        p     <= PW'(prec) + nlsu_pkg::red_extra(6'(k));
      end
      nlsu_pkg::OP_SETUP: begin
        n        <= (int'(lut_n) > MAX_TERMS) ? IW'(MAX_TERMS) : IW'(lut_n);
        i        <= IW'(1);
        pw_neg   <= u_neg;
        pw_mag   <= u_mag;
        pw04_mag <= nlsu_pkg::ARG_04;
        acc      <= '0;
        acc04    <= '0;
      end
      nlsu_pkg::OP_TACC: begin
        if (pw_neg ^ ~i[0]) acc <= acc - term_e;
        else acc <= acc + term_e;
      end
      nlsu_pkg::OP_T04ACC: begin
        if (~i[0]) acc04 <= acc04 - term_e;
        else acc04 <= acc04 + term_e;
      end
      nlsu_pkg::OP_MUL, nlsu_pkg::OP_MUL04: prod <= mul_a * mul_b;
      nlsu_pkg::OP_MULW: begin
        pw_mag <= rounded;
        pw_neg <= pw_neg ^ u_neg;
      end
      nlsu_pkg::OP_MUL04W: pw04_mag <= rounded;
      nlsu_pkg::OP_NEXT:   i <= i + IW'(1);
      nlsu_pkg::OP_KMUL:   kprod <= $signed({1'b0, k}) * acc04;
      nlsu_pkg::OP_SUM:    res <= kprod + RW'(acc);
      nlsu_pkg::OP_CONV: begin
        rneg <= res[RW-1];
        rmag <= (res_abs + RND) >> SH;
      end
      nlsu_pkg::OP_SAT: begin
        log_value <= rneg ? 32'(-sat_m) : 32'(sat_m);
        status    <= nlsu_pkg::STATUS_OK;
      end
      default: ;
    endcase
  end

endmodule

### rtl/core/nlsu_ctrl.sv
module nlsu_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  nlsu_pkg::dp_status_t st,
  output nlsu_pkg::dp_op_t     op,
  output logic                 busy,
  output logic                 done
);

  nlsu_pkg::state_t state;
  nlsu_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= nlsu_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    op         = nlsu_pkg::OP_NONE;
    busy       = (state != nlsu_pkg::S_IDLE);
    done       = (state == nlsu_pkg::S_OUT);
    case (state)
      nlsu_pkg::S_IDLE: begin
        if (start) begin
          op         = nlsu_pkg::OP_LOAD;
          state_next = nlsu_pkg::S_CLASS;
        end
      end
      nlsu_pkg::S_CLASS: begin
        op = nlsu_pkg::OP_CLASSIFY;
        if (st.cls_red) state_next = nlsu_pkg::S_RTEST;
        else if (st.cls_dir) state_next = nlsu_pkg::S_SETUP;
        else state_next = nlsu_pkg::S_OUT;
      end
      nlsu_pkg::S_RTEST: begin
        if (st.red_more) begin
          op         = nlsu_pkg::OP_RDIV_GO;
          state_next = nlsu_pkg::S_RDIV;
        end else begin
          op         = nlsu_pkg::OP_RFIN;
          state_next = nlsu_pkg::S_SETUP;
        end
      end
      nlsu_pkg::S_RDIV: begin
        if (st.div_done) begin
          op         = nlsu_pkg::OP_RDIV_END;
          state_next = nlsu_pkg::S_RTEST;
        end
      end
      nlsu_pkg::S_SETUP: begin
        op         = nlsu_pkg::OP_SETUP;
        state_next = nlsu_pkg::S_TGO;
      end
      nlsu_pkg::S_TGO: begin
        op         = nlsu_pkg::OP_TDIV_GO;
        state_next = nlsu_pkg::S_TDIV;
      end
      nlsu_pkg::S_TDIV: begin
        if (st.div_done) begin
          op = nlsu_pkg::OP_TACC;
          if (st.dual) state_next = nlsu_pkg::S_T04GO;
          else if (st.last) state_next = nlsu_pkg::S_KMUL;
          else state_next = nlsu_pkg::S_MUL;
        end
      end
      nlsu_pkg::S_T04GO: begin
        op         = nlsu_pkg::OP_T04_GO;
        state_next = nlsu_pkg::S_T04;
      end
      nlsu_pkg::S_T04: begin
        if (st.div_done) begin
          op         = nlsu_pkg::OP_T04ACC;
          state_next = st.last ? nlsu_pkg::S_KMUL : nlsu_pkg::S_MUL;
        end
      end
      nlsu_pkg::S_MUL: begin
        op         = nlsu_pkg::OP_MUL;
        state_next = nlsu_pkg::S_MULW;
      end
      nlsu_pkg::S_MULW: begin
        op         = nlsu_pkg::OP_MULW;
        state_next = st.dual ? nlsu_pkg::S_MUL04 : nlsu_pkg::S_NEXT;
      end
      nlsu_pkg::S_MUL04: begin
        op         = nlsu_pkg::OP_MUL04;
        state_next = nlsu_pkg::S_MUL04W;
      end
      nlsu_pkg::S_MUL04W: begin
        op         = nlsu_pkg::OP_MUL04W;
        state_next = nlsu_pkg::S_NEXT;
      end
      nlsu_pkg::S_NEXT: begin
        op         = nlsu_pkg::OP_NEXT;
        state_next = nlsu_pkg::S_TGO;
      end
      nlsu_pkg::S_KMUL: begin
        op         = nlsu_pkg::OP_KMUL;
        state_next = nlsu_pkg::S_SUM;
      end
      nlsu_pkg::S_SUM: begin
        op         = nlsu_pkg::OP_SUM;
        state_next = nlsu_pkg::S_CONV;
      end
      nlsu_pkg::S_CONV: begin
        op         = nlsu_pkg::OP_CONV;
        state_next = nlsu_pkg::S_SAT;
      end
      nlsu_pkg::S_SAT: begin
        op         = nlsu_pkg::OP_SAT;
        state_next = nlsu_pkg::S_OUT;
      end
      nlsu_pkg::S_OUT: state_next = nlsu_pkg::S_IDLE;
      default: state_next = nlsu_pkg::S_IDLE;
    endcase
  end

endmodule

### rtl/core/natural_log_series_unit.sv
// ln(1+x) unit, signed fixed point in and out (FRAC_BITS fraction bits).
// command channel: x_value is taken on a clock edge with start high and busy
// low; busy stays high until the result beat has gone out.
// result channel: log_value and status sit on the ports with done high for
// exactly one cycle; the receiver cannot stall, so nothing is held back.
// config channel: cfg_data (decimal places) is written when cfg_valid and
// cfg_ready are high; cfg_ready is always high. write it only while idle.
// one serial divider, four quotient bits per cycle, NW quotient bits (NW is
// set by FRAC_BITS, 44 at 24 fraction bits). reduction divides by 1.4, up
// to MAX_REDUCTIONS times. when the argument is reduced the 0.4 series runs
// beside the main one; the last term skips the power update. the term count
// n comes from the decimals, plus floor(k/5)+1 after k reductions (16 terms
// at six decimals when unreduced). setup runs before the series, scaling,
// rounding and saturation after it. an unsupported or out-of-domain x goes
// straight from classification to the result beat.
// one item is in flight at a time.
// reset: synchronous, returns to idle and sets decimals to 6.
module natural_log_series_unit #(
  parameter int MAX_TERMS      = 32,
  parameter int MAX_REDUCTIONS = 16,
  parameter int FRAC_BITS      = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] x_value,
  output logic               done,
  output logic signed [31:0] log_value,
  output logic [1:0]         status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_data
);

  nlsu_pkg::dp_op_t     op;
  nlsu_pkg::dp_status_t st;

  assign cfg_ready = 1'b1;

  nlsu_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .op    (op),
    .busy  (busy),
    .done  (done)
  );

  nlsu_dp #(
    .MAX_TERMS      (MAX_TERMS),
    .MAX_REDUCTIONS (MAX_REDUCTIONS),
    .FRAC_BITS      (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .x_value   (x_value),
    .st        (st),
    .log_value (log_value),
    .status    (status)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result beat while idle");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != nlsu_pkg::STATUS_OK) |-> (log_value == 32'sd0))
    else $error("nonzero result with error status");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == nlsu_pkg::STATUS_OK || status == nlsu_pkg::STATUS_UNSUP ||
              status == nlsu_pkg::STATUS_DOMAIN))
    else $error("undefined status code");

endmodule

### sim/natural_log_series_unit_checker.sv
`timescale 1ns / 100ps

module natural_log_series_unit_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] x_value,
  input  logic               done,
  input  logic signed [31:0] log_value,
  input  logic [1:0]         status,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_data,
  output int                 fail_count,
  output int                 pending
);

  localparam int MAX_TERMS      = 32;
  localparam int MAX_REDUCTIONS = 16;
  localparam int FRAC_BITS      = 24;
  localparam int IBITS          = nlsu_pkg::IBITS;
  localparam longint QONE       = 64'sd1 << IBITS;
  localparam longint HALF_04    = 64'sd429496730;

  typedef struct {
    logic signed [31:0] log_value;
    logic [1:0]         status;
  } log_result_t;

  log_result_t expected_logs[$];
  logic [2:0]  decimals;

  function automatic longint mul_round(longint a, longint b);
    logic    neg;
    longint  ma;
    longint  mb;
    longint  m;
    neg = (a < 0) != (b < 0);
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    m = (ma * mb + (64'sd1 << (IBITS - 1))) >>> IBITS;
    return neg ? -m : m;
  endfunction

  function automatic int terms_for(int p);
    longint lim;
    int     n;
    lim = 1;
    for (int i = 0; i < p; i++) lim = lim * 10;
    for (n = 0; n < MAX_TERMS; n++) begin
      if (lim < ((64'sd1 << n) * longint'(n + 1))) break;
    end
    return n;
  endfunction

  function automatic longint log_series(int n, longint u);
    longint acc;
    longint pw;
    acc = 0;
    pw = u;
    for (int i = 1; i <= n; i++) begin
      if (i % 2) acc = acc + pw / i;
      else acc = acc - pw / i;
      pw = mul_round(pw, u);
    end
    return acc;
  endfunction

  function automatic log_result_t predict_log(logic signed [31:0] x, logic [2:0] d);
    log_result_t r;
    longint      xq;
    longint      y;
    longint      u;
    longint      acc;
    longint      m;
    int          k;
    int          n;
    int          sh;
    logic        neg;
    xq = longint'(x) <<< (IBITS - FRAC_BITS);
    r.log_value = '0;
    r.status = nlsu_pkg::STATUS_OK;
    if (5 * xq >= 2 * QONE) begin
      y = xq + QONE;
      k = 0;
      while (5 * y >= 7 * QONE && k < MAX_REDUCTIONS) begin
        y = (y * 5) / 7;
        k++;
      end
      u = (5 * y >= 7 * QONE) ? HALF_04 : y - QONE;
      n = terms_for(int'(d) + (k + 5) / 5);
      acc = longint'(k) * log_series(n, HALF_04) + log_series(n, u);
    end else if (5 * xq >= -3 * QONE) begin
      acc = log_series(terms_for(int'(d)), xq);
    end else begin
      r.status = (xq <= -QONE) ? nlsu_pkg::STATUS_DOMAIN : nlsu_pkg::STATUS_UNSUP;
      return r;
    end
    sh = IBITS - FRAC_BITS;
    neg = acc < 0;
    m = neg ? -acc : acc;
    if (sh > 0) m = (m + (64'sd1 << (sh - 1))) >>> sh;
    if (m > 64'sd2147483647 + (neg ? 1 : 0)) m = 64'sd2147483647 + (neg ? 1 : 0);
    r.log_value = 32'(neg ? -m : m);
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  assign pending = expected_logs.size();

  always @(posedge clk) begin
    log_result_t want;
    if (rst) begin
      decimals <= nlsu_pkg::PREC_RESET;
      fail_count = 0;
      expected_logs.delete();
    end else begin
      if (cfg_valid && cfg_ready) decimals <= cfg_data;
      if (start && !busy) expected_logs.push_back(predict_log(x_value, decimals));
      if (done) begin
        if (expected_logs.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = expected_logs.pop_front();
          if (log_value !== want.log_value)
            report_mismatch($sformatf("log_value %h, want %h", log_value, want.log_value));
          if (status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", status, want.status));
        end
      end
    end
  end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 20;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [31:0] x_value;
  logic               done;
  logic signed [31:0] log_value;
  logic [1:0]         status;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_data;
  int                 fail_count;
  int                 pending;
  int                 idle_cycles;

  natural_log_series_unit DUT (
    .clk, .rst, .start, .busy, .x_value, .done, .log_value, .status,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  natural_log_series_unit_checker checker_i (
    .clk, .rst, .start, .busy, .x_value, .done, .log_value, .status,
    .cfg_valid, .cfg_ready, .cfg_data, .fail_count, .pending
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog: cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL natural_log_series_unit");
        $finish;
      end
    end
  end

  task automatic send_x(logic signed [31:0] x);
    start <= 1'b1;
    x_value <= x;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_decimals(logic [2:0] d);
    cfg_valid <= 1'b1;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [31:0] random_x();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0000_9999)) - 32'sh0099_9999;
      2, 3: return 32'sh0066_6666 + $signed($urandom_range(0, 32'h0800_0000));
      4: return 32'sh0066_6666 + $signed($urandom_range(0, 32'h7f00_0000));
      default: return -32'sh0099_9999 + $signed($urandom_range(0, 32'h0100_0000));
    endcase
  endfunction

  // burst of random items with random gaps
  task automatic run_random(int count);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && left > 0) begin
        send_x(random_x());
        burst--;
        left--;
      end
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 300)) @(posedge clk);
    end
  endtask

  logic signed [31:0] directed_x[] = '{
    32'sh0000_0000, 32'sh0000_0001, -32'sh0000_0001, 32'sh0066_6665, 32'sh0066_6666,
    32'sh0066_6667, -32'sh0099_9999, -32'sh0099_999a, -32'sh00ff_ffff, -32'sh0100_0000,
    -32'sh0100_0001, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh0100_0000, 32'sh0166_6666,
    32'sh0400_0000, 32'sh2000_0000, -32'sh0080_0000, 32'sh0050_0000, 32'shffff_ffff
  };

  initial begin
    rst = 1'b1;
    start = 1'b0;
    x_value = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    idle_cycles = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_x[i]) send_x(directed_x[i]);
    wait_drained();
    for (int d = 0; d < 8; d++) begin
      write_decimals(3'(d));
      send_x(32'sh7fff_ffff);
      send_x(32'sh0066_6666);
      send_x(-32'sh0099_9999);
      wait_drained();
    end
    foreach (directed_x[i]) begin
      write_decimals(3'($urandom_range(0, 7)));
      run_random(1);
      wait_drained();
    end
    write_decimals(3'd7);
    run_random(100);
    wait_drained();
    write_decimals(3'd1);
    run_random(100);
    wait_drained();
    write_decimals(3'd0);
    run_random(80);
    wait_drained();
    write_decimals(3'($urandom_range(0, 7)));
    run_random(100);
    wait_drained();
    if (fail_count == 0) begin
      $display("PASS natural_log_series_unit");
    end else begin
      $display("FAIL natural_log_series_unit");
    end
    $finish;
  end

endmodule
